// ===== rtl/pdca_pkg.sv =====
// ----------------------------------------------------------------------------
// pdca_pkg
// Shared types and constants for the clamped PID controller with DAC stage.
// ----------------------------------------------------------------------------
package pdca_pkg;

    // stream and register port geometry
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int DIGIT_W   = 16;

    // item kinds carried in s_tuser
    typedef enum logic [1:0] {
        OP_STEP   = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_PRESET = 2'd2
    } op_t;

    // register index, byte address is 4 * index
    typedef enum logic [2:0] {
        REG_KP      = 3'd0,
        REG_KI      = 3'd1,
        REG_KD      = 3'd2,
        REG_LOWER   = 3'd3,
        REG_UPPER   = 3'd4,
        REG_DGAIN   = 3'd5,
        REG_DOFFSET = 3'd6
    } reg_idx_t;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUMS,
        ST_MP,
        ST_WP,
        ST_MI,
        ST_WI,
        ST_PI,
        ST_MD,
        ST_WD,
        ST_MG,
        ST_WG,
        ST_FIN
    } ctrl_state_t;

    // datapath operations
    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_PRESET,
        DP_ERR,
        DP_SUMS,
        DP_MUL_P,
        DP_MUL_I,
        DP_MUL_D,
        DP_MUL_G,
        DP_SET_P,
        DP_SET_I,
        DP_ADD_PI,
        DP_ADD_D,
        DP_SET_K,
        DP_FINISH
    } dp_op_t;

    // multiplier sequencing
    typedef enum logic [1:0] {
        MP_IDLE,
        MP_ACC,
        MP_RND,
        MP_SAT
    } mul_phase_t;

    // controller to datapath
    typedef struct packed {
        dp_op_t op;
        logic   mul_start;
    } pdca_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic mul_done;
        logic out_busy;
    } pdca_sts_t;

    // register write request
    typedef struct packed {
        logic              wr;
        logic [2:0]        idx;
        logic [APB_DW-1:0] data;
    } pdca_cfg_wr_t;

endpackage

// ===== rtl/pdca_mul.sv =====
// ----------------------------------------------------------------------------
// pdca_mul
// Iterative signed fixed-point multiplier: magnitude product one 16-bit digit
// per cycle, round half away from zero, shift by the fraction, saturate.
// ----------------------------------------------------------------------------
module pdca_mul #(
    parameter int DW   = 32,
    parameter int FRAC = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [DW-1:0] a_in,
    input  logic signed [DW-1:0] b_in,
    output logic                 done,
    output logic signed [DW-1:0] result
);
    import pdca_pkg::*;

    localparam int NDIG  = (DW + DIGIT_W - 1) / DIGIT_W;
    localparam int MB_W  = DIGIT_W * NDIG;
    localparam int ACC_W = DW + MB_W;
    localparam int CNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int PP_W  = DW + DIGIT_W;

    localparam logic [ACC_W-1:0] HALF    = ACC_W'(1) << (FRAC - 1);
    localparam logic [ACC_W-1:0] LIM_NEG = ACC_W'(1) << (DW - 1);
    localparam logic [ACC_W-1:0] LIM_POS = LIM_NEG - ACC_W'(1);
    localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

    mul_phase_t        phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic [DW-1:0]     ma_reg, ma_next;
    logic [MB_W-1:0]   mb_reg, mb_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [DW-1:0] res_reg, res_next;
    logic              done_reg, done_next;

    logic [DW-1:0]     a_mag, b_mag, mag, mag_neg;
    logic [PP_W-1:0]   pp, acc_sum;

    // operand magnitudes, most negative value maps to 2^(DW-1)
    assign a_mag = a_in[DW-1] ? DW'(~a_in + 1'b1) : DW'(a_in);
    assign b_mag = b_in[DW-1] ? DW'(~b_in + 1'b1) : DW'(b_in);

    // one digit of partial product added to the upper accumulator half
    assign pp      = PP_W'(ma_reg) * PP_W'(mb_reg[DIGIT_W-1:0]);
    assign acc_sum = PP_W'(acc_reg[ACC_W-1 -: DW]) + pp;

    assign mag     = acc_reg[DW-1:0];
    assign mag_neg = DW'(~mag + 1'b1);

    // sequencing
    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        unique case (phase_reg)
            MP_IDLE: begin
                if (start) begin
                    neg_next   = a_in[DW-1] ^ b_in[DW-1];
                    ma_next    = a_mag;
                    mb_next    = MB_W'(b_mag);
                    acc_next   = '0;
                    cnt_next   = '0;
                    phase_next = MP_ACC;
                end
            end
            MP_ACC: begin
                acc_next = ACC_W'({acc_sum, acc_reg[ACC_W-DW-1:0]} >> DIGIT_W);
                mb_next  = mb_reg >> DIGIT_W;
                cnt_next = CNT_W'(cnt_reg + 1'b1);
                if (cnt_reg == CNT_W'(NDIG - 1)) begin
                    phase_next = MP_RND;
                end
            end
            MP_RND: begin
                acc_next   = (acc_reg + HALF) >> FRAC;
                phase_next = MP_SAT;
            end
            MP_SAT: begin
                if (acc_reg > (neg_reg ? LIM_NEG : LIM_POS)) begin
                    res_next = neg_reg ? VMIN : VMAX;
                end else begin
                    res_next = neg_reg ? mag_neg : mag;
                end
                done_next  = 1'b1;
                phase_next = MP_IDLE;
            end
            default: begin
                phase_next = MP_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= MP_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== rtl/pdca_datapath.sv =====
// ----------------------------------------------------------------------------
// pdca_datapath
// Registers, state, saturating adders, shared multiplier, clamp with
// conditional integrator commit, and the result register.
// ----------------------------------------------------------------------------
module pdca_datapath #(
    parameter int DW   = 32,
    parameter int FRAC = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  pdca_pkg::pdca_cmd_t         cmd,
    output pdca_pkg::pdca_sts_t         sts,
    input  pdca_pkg::pdca_cfg_wr_t      cfg_wr,
    input  logic [2:0]                  rd_idx,
    output logic [pdca_pkg::APB_DW-1:0] rd_data,
    input  logic [31:0]                 setpoint,
    input  logic [31:0]                 measured,
    input  logic [31:0]                 preset_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [31:0]                 drive,
    output logic                        at_upper,
    output logic                        at_lower
);
    import pdca_pkg::*;

    localparam int EW = (DW > 32) ? DW : 32;
    localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

    // 32-bit two's complement to DW bits with saturation
    function automatic logic signed [DW-1:0] from32(input logic [31:0] v);
        logic signed [EW-1:0] e;
        logic signed [DW-1:0] r;
        e = EW'(signed'(v));
        if (e > EW'(VMAX)) begin
            r = VMAX;
        end else if (e < EW'(VMIN)) begin
            r = VMIN;
        end else begin
            r = e[DW-1:0];
        end
        return r;
    endfunction

    // clip a DW+1 bit sum back into DW bits
    function automatic logic signed [DW-1:0] clip(input logic [DW:0] s);
        logic signed [DW-1:0] r;
        if (s[DW] != s[DW-1]) begin
            r = s[DW] ? VMIN : VMAX;
        end else begin
            r = s[DW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DW-1:0] add_sat(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
        return clip({a[DW-1], a} + {b[DW-1], b});
    endfunction

    function automatic logic signed [DW-1:0] sub_sat(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
        return clip({a[DW-1], a} - {b[DW-1], b});
    endfunction

    // registers
    logic signed [DW-1:0] kp_reg, ki_reg, kd_reg, lower_reg, upper_reg;
    logic signed [DW-1:0] dgain_reg, doffset_reg;
    // stored state and work values
    logic signed [DW-1:0] integ_reg, prev_reg, err_reg, esum_reg, edif_reg;
    logic signed [DW-1:0] p_reg, inew_reg, y_reg, k_reg;
    // result register
    logic                 ovalid_reg;
    logic signed [DW-1:0] odrive_reg;
    logic                 oup_reg, olo_reg;

    logic signed [DW-1:0] mul_a, mul_b, mres;
    logic                 mdone;
    logic signed [DW-1:0] upper_w;

    // operand selection for the shared multiplier
    always_comb begin
        case (cmd.op)
            DP_MUL_P: begin
                mul_a = kp_reg;
                mul_b = err_reg;
            end
            DP_MUL_I: begin
                mul_a = ki_reg;
                mul_b = esum_reg;
            end
            DP_MUL_D: begin
                mul_a = kd_reg;
                mul_b = edif_reg;
            end
            DP_MUL_G: begin
                mul_a = dgain_reg;
                mul_b = y_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    pdca_mul #(
        .DW   (DW),
        .FRAC (FRAC)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .done    (mdone),
        .result  (mres)
    );

    assign upper_w = upper_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg      <= '0;
            ki_reg      <= '0;
            kd_reg      <= '0;
            lower_reg   <= '0;
            upper_reg   <= '0;
            dgain_reg   <= '0;
            doffset_reg <= '0;
        end else if (cfg_wr.wr) begin
            unique case (reg_idx_t'(cfg_wr.idx))
                REG_KP:      kp_reg      <= from32(cfg_wr.data);
                REG_KI:      ki_reg      <= from32(cfg_wr.data);
                REG_KD:      kd_reg      <= from32(cfg_wr.data);
                REG_LOWER:   lower_reg   <= from32(cfg_wr.data);
                REG_UPPER:   upper_reg   <= from32(cfg_wr.data);
                REG_DGAIN:   dgain_reg   <= from32(cfg_wr.data);
                REG_DOFFSET: doffset_reg <= from32(cfg_wr.data);
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (reg_idx_t'(rd_idx))
            REG_KP:      rd_data = APB_DW'(kp_reg);
            REG_KI:      rd_data = APB_DW'(ki_reg);
            REG_KD:      rd_data = APB_DW'(kd_reg);
            REG_LOWER:   rd_data = APB_DW'(lower_reg);
            REG_UPPER:   rd_data = APB_DW'(upper_reg);
            REG_DGAIN:   rd_data = APB_DW'(dgain_reg);
            REG_DOFFSET: rd_data = APB_DW'(doffset_reg);
            default:     rd_data = '0;
        endcase
    end

    // controller state: integrator and previous error
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
            prev_reg  <= '0;
        end else begin
            case (cmd.op)
                DP_CLEAR: begin
                    integ_reg <= '0;
                    prev_reg  <= '0;
                end
                DP_PRESET: begin
                    integ_reg <= from32(preset_value);
                end
                DP_FINISH: begin
                    prev_reg <= err_reg;
                    // commit only when unclamped or the error backs off the limit
                    if (k_reg > upper_reg) begin
                        if (err_reg < 0) integ_reg <= inew_reg;
                    end else if (k_reg < lower_reg) begin
                        if (err_reg > 0) integ_reg <= inew_reg;
                    end else begin
                        integ_reg <= inew_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // work values of one control step
    always_ff @(posedge aclk) begin
        case (cmd.op)
            DP_ERR:    err_reg  <= sub_sat(from32(setpoint), from32(measured));
            DP_SUMS: begin
                esum_reg <= add_sat(err_reg, prev_reg);
                edif_reg <= sub_sat(err_reg, prev_reg);
            end
            DP_SET_P:  p_reg    <= mres;
            DP_SET_I:  inew_reg <= add_sat(integ_reg, mres);
            DP_ADD_PI: y_reg    <= add_sat(p_reg, inew_reg);
            DP_ADD_D:  y_reg    <= add_sat(y_reg, mres);
            DP_SET_K:  k_reg    <= add_sat(mres, doffset_reg);
            default: ;
        endcase
    end

    // result register, loads when the previous beat leaves
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (cmd.op == DP_FINISH) begin
            ovalid_reg <= 1'b1;
        end else if (out_ready) begin
            ovalid_reg <= 1'b0;
        end
    end

    // clamp, upper test first
    always_ff @(posedge aclk) begin
        if (cmd.op == DP_FINISH) begin
            if (k_reg > upper_reg) begin
                odrive_reg <= upper_w;
                oup_reg    <= 1'b1;
                olo_reg    <= 1'b0;
            end else if (k_reg < lower_reg) begin
                odrive_reg <= lower_reg;
                oup_reg    <= 1'b0;
                olo_reg    <= 1'b1;
            end else begin
                odrive_reg <= k_reg;
                oup_reg    <= 1'b0;
                olo_reg    <= 1'b0;
            end
        end
    end

    assign sts.mul_done = mdone;
    assign sts.out_busy = ovalid_reg & ~out_ready;

    assign out_valid = ovalid_reg;
    assign drive     = 32'(odrive_reg);
    assign at_upper  = oup_reg;
    assign at_lower  = olo_reg;

endmodule

// ===== rtl/pdca_ctrl.sv =====
// ----------------------------------------------------------------------------
// pdca_ctrl
// Sequencer for one item: error, sums, four products, adds, clamp and commit.
// ----------------------------------------------------------------------------
module pdca_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic [1:0]          in_op,
    output logic                in_ready,
    input  pdca_pkg::pdca_sts_t sts,
    output pdca_pkg::pdca_cmd_t cmd
);
    import pdca_pkg::*;

    ctrl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        cmd.op        = DP_NOP;
        cmd.mul_start = 1'b0;
        in_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    case (op_t'(in_op))
                        OP_STEP: begin
                            cmd.op     = DP_ERR;
                            state_next = ST_SUMS;
                        end
                        OP_CLEAR:  cmd.op = DP_CLEAR;
                        OP_PRESET: cmd.op = DP_PRESET;
                        default: ;
                    endcase
                end
            end
            ST_SUMS: begin
                cmd.op     = DP_SUMS;
                state_next = ST_MP;
            end
            ST_MP: begin
                cmd.op        = DP_MUL_P;
                cmd.mul_start = 1'b1;
                state_next    = ST_WP;
            end
            ST_WP: begin
                if (sts.mul_done) begin
                    cmd.op     = DP_SET_P;
                    state_next = ST_MI;
                end
            end
            ST_MI: begin
                cmd.op        = DP_MUL_I;
                cmd.mul_start = 1'b1;
                state_next    = ST_WI;
            end
            ST_WI: begin
                if (sts.mul_done) begin
                    cmd.op     = DP_SET_I;
                    state_next = ST_PI;
                end
            end
            ST_PI: begin
                cmd.op     = DP_ADD_PI;
                state_next = ST_MD;
            end
            ST_MD: begin
                cmd.op        = DP_MUL_D;
                cmd.mul_start = 1'b1;
                state_next    = ST_WD;
            end
            ST_WD: begin
                if (sts.mul_done) begin
                    cmd.op     = DP_ADD_D;
                    state_next = ST_MG;
                end
            end
            ST_MG: begin
                cmd.op        = DP_MUL_G;
                cmd.mul_start = 1'b1;
                state_next    = ST_WG;
            end
            ST_WG: begin
                if (sts.mul_done) begin
                    cmd.op     = DP_SET_K;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // hold until the result register is free
                if (!sts.out_busy) begin
                    cmd.op     = DP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/pid_dac_clamped_antiwindup.sv =====
// ----------------------------------------------------------------------------
// pid_dac_clamped_antiwindup
// Discrete PID with trapezoidal integral, DAC gain and offset, output clamp
// and conditional integrator commit, fixed point with saturation.
// ----------------------------------------------------------------------------
//  channel   dir   handshake              contents
//  s_        in    s_tvalid / s_tready    setpoint, measured, preset; op in tuser
//  m_        out   m_tvalid / m_tready    drive, at_upper, at_lower
//  apb       in    psel / penable         seven gain and limit registers
//
//  a control step runs error, sums, the P and I products, the P+I add, the D
//  and gain products, then clamp and commit; s_tready is back in the cycle
//  m_tvalid rises. the one shared multiplier takes one 16-bit digit a cycle.
//  clear, preset and unused ops are taken in idle and make no result.
//  reset is synchronous and active low; registers and state return to zero.
//  a result waiting on m_tready does not block acceptance of the next beat;
//  a step finishing behind it waits for the result register.
// ----------------------------------------------------------------------------
module pid_dac_clamped_antiwindup #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input beat
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pdca_pkg::S_TDATA_W-1:0] s_tdata,  // setpoint, measured, preset_value
    input  logic [pdca_pkg::S_TUSER_W-1:0] s_tuser,  // op
    // result beat
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pdca_pkg::M_TDATA_W-1:0] m_tdata,  // drive, at_upper, at_lower, zero pad
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pdca_pkg::APB_AW-1:0]    paddr,
    input  logic [pdca_pkg::APB_DW-1:0]    pwdata,
    output logic [pdca_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);
    import pdca_pkg::*;

    pdca_cmd_t    cmd;
    pdca_sts_t    sts;
    pdca_cfg_wr_t cfg_wr;
    logic [31:0]  drive;
    logic         at_upper, at_lower;

    // register write on the access cycle
    assign pready      = 1'b1;
    assign cfg_wr.wr   = psel & penable & pwrite & pready;
    assign cfg_wr.idx  = paddr[APB_AW-1:2];
    assign cfg_wr.data = pwdata;

    pdca_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pdca_datapath #(
        .DW   (DATA_WIDTH),
        .FRAC (FRAC_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_wr       (cfg_wr),
        .rd_idx       (paddr[APB_AW-1:2]),
        .rd_data      (prdata),
        .setpoint     (s_tdata[31:0]),
        .measured     (s_tdata[63:32]),
        .preset_value (s_tdata[95:64]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .drive        (drive),
        .at_upper     (at_upper),
        .at_lower     (at_lower)
    );

    assign m_tdata = {6'b0, at_lower, at_upper, drive};

endmodule

// ===== rtl/pdca_checker.sv =====
// ----------------------------------------------------------------------------
// pdca_checker
// Port-level checks for the clamped PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module pdca_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [pdca_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [pdca_pkg::M_TDATA_W-1:0] m_tdata
);
    import pdca_pkg::*;

    // a step closes the input side once it is accepted
    a_step_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_STEP) |=> !s_tready)
        else $error("input accepted during a control step");

    // clear, preset and unused ops make no result
    a_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser != OP_STEP && !m_tvalid) |=> !m_tvalid)
        else $error("result from an op that makes none");

    // a result is never clamped at both limits
    a_one_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[32] && m_tdata[33]))
        else $error("both clamp flags set");

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind pid_dac_clamped_antiwindup pdca_checker u_pdca_checker (.*);

// ===== sim/tb_pid_dac_clamped_antiwindup.sv =====
// ----------------------------------------------------------------------------
// tb_pid_dac_clamped_antiwindup
// Self-checking bench for the clamped PID controller with DAC stage. Control
// steps, clears, presets and unused ops go in over the input stream with
// random gaps. The bench tracks the integrator, the previous error and the
// register file in its own Q16.16 model, computes the expected drive and
// clamp flags for each step, and checks every result beat in order. Several
// register settings are run, including zero, full-scale and crossed limits.
// ----------------------------------------------------------------------------
import pdca_pkg::*;

// expected result of one control step
typedef struct packed {
    logic        at_lower;
    logic        at_upper;
    logic [31:0] drive;
} drive_beat_t;

class drive_scoreboard;
    longint      gain_reg [7];
    longint      integ;
    longint      prev_err;
    drive_beat_t drive_q [$];
    int          errors;

    function new();
        foreach (gain_reg[i]) gain_reg[i] = 0;
        integ    = 0;
        prev_err = 0;
        errors   = 0;
    endfunction

    // saturate to the signed 32-bit range
    function longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // q16.16 product, round half away from zero, saturate
    function longint mul_q(longint a, longint b);
        longint prod;
        longint mag;
        longint rnd;
        prod = a * b;
        mag  = (prod < 0) ? -prod : prod;
        rnd  = (mag + 64'sd32768) >>> 16;
        return sat32((prod < 0) ? -rnd : rnd);
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] value);
        gain_reg[idx] = longint'($signed(value));
    endfunction

    function int pending();
        return drive_q.size();
    endfunction

    // update the controller state for one accepted beat
    function void note_sample(logic [1:0] op, logic [31:0] sp, logic [31:0] ms,
                              logic [31:0] pv);
        longint      err;
        longint      p;
        longint      inew;
        longint      d;
        longint      y;
        longint      k;
        drive_beat_t r;
        case (op)
            OP_CLEAR: begin
                integ    = 0;
                prev_err = 0;
            end
            OP_PRESET: begin
                integ = longint'($signed(pv));
            end
            OP_STEP: begin
                err  = sat32(longint'($signed(sp)) - longint'($signed(ms)));
                p    = mul_q(gain_reg[REG_KP], err);
                inew = sat32(integ + mul_q(gain_reg[REG_KI], sat32(err + prev_err)));
                d    = mul_q(gain_reg[REG_KD], sat32(err - prev_err));
                y    = sat32(sat32(p + inew) + d);
                k    = sat32(mul_q(gain_reg[REG_DGAIN], y) + gain_reg[REG_DOFFSET]);
                r.at_upper = 1'b0;
                r.at_lower = 1'b0;
                // upper test first, integrator commits only when backing off
                if (k > gain_reg[REG_UPPER]) begin
                    k = gain_reg[REG_UPPER];
                    r.at_upper = 1'b1;
                    if (err < 0) integ = inew;
                end else if (k < gain_reg[REG_LOWER]) begin
                    k = gain_reg[REG_LOWER];
                    r.at_lower = 1'b1;
                    if (err > 0) integ = inew;
                end else begin
                    integ = inew;
                end
                prev_err = err;
                r.drive  = k[31:0];
                drive_q.push_back(r);
            end
            default: ;  // unused op leaves everything as is
        endcase
    endfunction

    // compare one result beat against the oldest expectation
    function void check_drive(logic [39:0] beat);
        drive_beat_t r;
        if (drive_q.size() == 0) begin
            errors++;
            $display("%0t: result beat %h with nothing expected", $time, beat);
            return;
        end
        r = drive_q.pop_front();
        if (beat[31:0] !== r.drive) begin
            errors++;
            $display("%0t: drive expected %h actual %h", $time, r.drive, beat[31:0]);
        end
        if (beat[32] !== r.at_upper) begin
            errors++;
            $display("%0t: at_upper expected %b actual %b", $time, r.at_upper, beat[32]);
        end
        if (beat[33] !== r.at_lower) begin
            errors++;
            $display("%0t: at_lower expected %b actual %b", $time, r.at_lower, beat[33]);
        end
    endfunction
endclass

module tb_pid_dac_clamped_antiwindup;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         NUM_REGS  = 7;
    localparam int         SETTLE    = 40;
    localparam int         PHASE_N   = 110;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // setpoint, measured, preset_value
    logic [S_TUSER_W-1:0]  s_tuser;   // op
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // drive, at_upper, at_lower, zero pad
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    drive_scoreboard       sb = new();
    logic [31:0]           reg_plan [NUM_REGS];
    bit                    s_calm;
    int                    s_calm_left;
    bit                    r_calm;
    int                    r_calm_left;

    pid_dac_clamped_antiwindup i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // gap before a beat, with stretches of back-to-back traffic
    function automatic int draw_gap(inout bit calm, inout int left);
        if (left == 0) begin
            calm = ($urandom_range(0, 2) == 0);
            left = $urandom_range(8, 40);
        end
        left--;
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    // mostly values within +-span, with full-scale and raw random ones
    function automatic logic [31:0] draw_value(int unsigned span);
        case ($urandom_range(0, 9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom;
            default: return $urandom_range(0, 2 * span) - span;
        endcase
    endfunction

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(idx, value);
    endtask

    // writes back to back, bus released after the last one
    task automatic program_regs();
        for (int i = 0; i < NUM_REGS; i++) apb_write(reg_idx_t'(i), reg_plan[i]);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // moderate gains and ordered (or crossed) limits
    task automatic plan_moderate(input bit crossed);
        logic [31:0] a;
        logic [31:0] b;
        reg_plan[REG_KP]      = $urandom_range(0, 32'h80000) - 32'h40000;
        reg_plan[REG_KI]      = $urandom_range(0, 32'h20000) - 32'h10000;
        reg_plan[REG_KD]      = $urandom_range(0, 32'h40000) - 32'h20000;
        reg_plan[REG_DGAIN]   = $urandom_range(0, 32'h80000) - 32'h40000;
        reg_plan[REG_DOFFSET] = $urandom_range(0, 32'h200000) - 32'h100000;
        a = $urandom_range(0, 32'h1000000) - 32'h800000;
        b = $urandom_range(0, 32'h1000000) - 32'h800000;
        if (($signed(a) > $signed(b)) != crossed) begin
            reg_plan[REG_LOWER] = b;
            reg_plan[REG_UPPER] = a;
        end else begin
            reg_plan[REG_LOWER] = a;
            reg_plan[REG_UPPER] = b;
        end
    endtask

    task automatic send_beat(input logic [1:0] op, input logic [31:0] sp,
                             input logic [31:0] ms, input logic [31:0] pv);
        int gap;
        gap = draw_gap(s_calm, s_calm_left);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {pv, ms, sp};
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(op, sp, ms, pv);
    endtask

    // random beats: mostly steps, half with errors near zero, some state and unused ops
    task automatic send_random(input int count, input int unsigned span);
        int          sel;
        logic [1:0]  op;
        logic [31:0] sp;
        logic [31:0] ms;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 80)      op = OP_STEP;
            else if (sel < 87) op = OP_CLEAR;
            else if (sel < 94) op = OP_PRESET;
            else               op = OP_UNUSED;
            sp = draw_value(span);
            if ($urandom_range(0, 1)) ms = sp + ($urandom_range(0, span / 4) - span / 8);
            else                      ms = draw_value(span);
            send_beat(op, sp, ms, draw_value(span));
        end
        s_tvalid <= 1'b0;
    endtask

    // idle until every result is back and the block has gone quiet
    task automatic settle();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // result side
    initial begin
        int gap;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            gap = draw_gap(r_calm, r_calm_left);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_drive(m_tdata);
        end
    end

    // stimulus
    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_STEP;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (2) @(posedge aclk);
        aresetn  <= 1'b1;

        // directed: unit kp, limits at +-100.0
        reg_plan[REG_KP]      = 32'h0001_0000;
        reg_plan[REG_KI]      = 32'h0000_4000;
        reg_plan[REG_KD]      = 32'h0000_8000;
        reg_plan[REG_LOWER]   = 32'hff9c_0000;
        reg_plan[REG_UPPER]   = 32'h0064_0000;
        reg_plan[REG_DGAIN]   = 32'h0001_0000;
        reg_plan[REG_DOFFSET] = 32'h0000_0000;
        program_regs();
        send_beat(OP_STEP,   32'h0000_0000, 32'h0000_0000, 32'h0);
        // one-lsb errors hit rounding ties
        send_beat(OP_STEP,   32'h0000_0001, 32'h0000_0000, 32'h0);
        send_beat(OP_STEP,   32'h0000_0000, 32'h0000_0001, 32'h0);
        // error saturates, clamp without integrator commit
        send_beat(OP_STEP,   32'h7fff_ffff, 32'h8000_0000, 32'h0);
        send_beat(OP_STEP,   32'h8000_0000, 32'h7fff_ffff, 32'h0);
        send_beat(OP_CLEAR,  32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        // wound-up integrator with error backing off the limit commits
        send_beat(OP_PRESET, 32'h0, 32'h0, 32'h7fff_ffff);
        send_beat(OP_STEP,   32'h0000_0000, 32'h0001_0000, 32'h0);
        send_beat(OP_PRESET, 32'h0, 32'h0, 32'h8000_0000);
        send_beat(OP_STEP,   32'h0001_0000, 32'h0000_0000, 32'h0);
        send_beat(OP_PRESET, 32'h0, 32'h0, 32'h0032_0000);
        send_beat(OP_STEP,   32'h0014_0000, 32'h000a_0000, 32'h0);
        send_beat(OP_UNUSED, $urandom, $urandom, $urandom);
        send_beat(OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_beat(OP_STEP,   32'h001e_0000, 32'hffec_0000, 32'h0);
        send_beat(OP_CLEAR,  32'h0, 32'h0, 32'h0);
        send_beat(OP_STEP,   32'hffd8_0000, 32'h0028_0000, 32'h0);
        send_beat(OP_STEP,   32'hff00_0000, 32'h0000_0000, 32'h0);
        send_beat(OP_PRESET, 32'h0, 32'h0, 32'h0);
        send_beat(OP_STEP,   32'h7fff_ffff, 32'h7fff_ffff, 32'h0);
        send_beat(OP_STEP,   32'h8000_0000, 32'h0000_0000, 32'h0);
        s_tvalid <= 1'b0;
        settle();

        // random gains, ordered limits
        plan_moderate(1'b0);
        program_regs();
        send_random(PHASE_N, 32'h0200_0000);
        settle();

        // raw random registers
        foreach (reg_plan[i]) reg_plan[i] = $urandom;
        program_regs();
        send_random(PHASE_N, 32'h0100_0000);
        settle();

        // crossed limits
        plan_moderate(1'b1);
        program_regs();
        send_random(PHASE_N, 32'h0200_0000);
        settle();

        // full-scale positive gains, widest limits, most negative offset
        reg_plan[REG_KP]      = 32'h7fff_ffff;
        reg_plan[REG_KI]      = 32'h7fff_ffff;
        reg_plan[REG_KD]      = 32'h7fff_ffff;
        reg_plan[REG_LOWER]   = 32'h8000_0000;
        reg_plan[REG_UPPER]   = 32'h7fff_ffff;
        reg_plan[REG_DGAIN]   = 32'h7fff_ffff;
        reg_plan[REG_DOFFSET] = 32'h8000_0000;
        program_regs();
        send_random(40, 32'h0001_0000);
        settle();

        // everything but the upper limit at the negative extreme
        foreach (reg_plan[i]) reg_plan[i] = 32'h8000_0000;
        reg_plan[REG_UPPER] = 32'h7fff_ffff;
        program_regs();
        send_random(40, 32'h0001_0000);
        settle();

        // all registers zero
        foreach (reg_plan[i]) reg_plan[i] = 32'h0;
        program_regs();
        send_random(30, 32'h0100_0000);
        settle();

        plan_moderate(1'b0);
        program_regs();
        send_random(PHASE_N, 32'h0040_0000);
        settle();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
